// ===== hdl/dmpd_pkg.sv =====
// Shared types and constants of the DCC mobile packet decoder.
// Used by every module under hdl but dmpd_fifo; depends on nothing.
`timescale 1ns / 1ps

package dmpd_pkg;

  // Packet record geometry: decode never looks past byte 4
  localparam int REC_BYTES = 5;
  localparam int SIZE_W    = 4;
  localparam int PADDR_W   = 5;
  localparam int REG_IDX_W = 3;

  // Register indexes on the configuration port
  localparam logic [REG_IDX_W-1:0] REG_SHORT_ADDR = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LONG_HIGH  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LONG_LOW   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CONSIST    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MODE       = 3'd4;

  // Register reset values
  localparam logic [7:0] RST_SHORT_ADDR = 8'd3;
  localparam logic [7:0] RST_LONG_HIGH  = 8'd192;
  localparam logic [7:0] RST_LONG_LOW   = 8'd0;
  localparam logic [7:0] RST_CONSIST    = 8'd0;
  localparam logic [7:0] RST_MODE       = 8'd0;

  // Address limits
  localparam logic [7:0] SHORT_ADDR_MIN = 8'd3;
  localparam logic [7:0] SHORT_ADDR_MAX = 8'd127;
  localparam logic [7:0] LONG_HIGH_MIN  = 8'd192;
  localparam logic [7:0] LONG_HIGH_MAX  = 8'd231;
  localparam int         MODE_LONG_BIT  = 4;

  // Instruction codes
  localparam logic [7:0] INSTR_CV_WRITE_MASK = 8'hFC;
  localparam logic [7:0] INSTR_CV_WRITE      = 8'hEC;
  localparam logic [7:0] INSTR_SPEED_128     = 8'h3F;
  localparam logic [7:0] INSTR_FG1_MASK      = 8'hE0;
  localparam logic [7:0] INSTR_FG1           = 8'h80;
  localparam logic [7:0] INSTR_FG2_MASK      = 8'hF0;
  localparam logic [7:0] INSTR_FG2_LOW       = 8'hB0;
  localparam logic [7:0] INSTR_FG2_HIGH      = 8'hA0;
  localparam logic [7:0] INSTR_F13_F20       = 8'hDE;
  localparam logic [7:0] INSTR_F21_F28       = 8'hDF;

  // CV numbers and values with special meaning
  localparam logic [7:0] CV_RESET_INDEX = 8'd7;
  localparam logic [7:0] CV_RESET_VALUE = 8'd8;
  localparam logic [8:0] CV_MODE_NUMBER = 9'd29;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte_flag;
  } in_item_t;

  typedef struct packed {
    logic        address_matched;
    logic [6:0]  speed_step;
    logic        direction_out;
    logic [28:0] function_outputs;
    logic        state_changed;
    logic        cv_write_valid;
    logic [8:0]  cv_number;
    logic [7:0]  cv_value;
    logic        decoder_reset_request;
  } result_t;

  // One complete packet as handed from the front to the back
  typedef struct packed {
    logic [REC_BYTES-1:0][7:0] bytes;
    logic [SIZE_W-1:0]         size;
    logic [7:0]                final_byte;
  } pkt_rec_t;

  typedef struct packed {
    logic [7:0] short_addr;
    logic [7:0] long_high;
    logic [7:0] long_low;
    logic [7:0] consist;
    logic [7:0] mode;
  } cfg_regs_t;

  typedef struct packed {
    logic       en;
    logic [7:0] value;
  } mode_wr_t;

endpackage

// ===== hdl/dmpd_fifo.sv =====
// Two-entry queue with registered storage and occupancy count.
// Depends on nothing; the payload width is a parameter.
`timescale 1ns / 1ps

module dmpd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rdata   = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Store the pushed request
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== hdl/dmpd_front.sv =====
// Front of the decoder: collects packet bytes and hands complete packets on.
// Depends on dmpd_pkg.
`timescale 1ns / 1ps

module dmpd_front #(
  parameter int MAX_PACKET_BYTES = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  dmpd_pkg::in_item_t byte_item,
  output logic               rec_push,
  output dmpd_pkg::pkt_rec_t rec
);

  localparam int CW   = $clog2(MAX_PACKET_BYTES + 1);
  localparam int KEEP = (MAX_PACKET_BYTES < dmpd_pkg::REC_BYTES) ?
                        MAX_PACKET_BYTES : dmpd_pkg::REC_BYTES;

  logic [CW-1:0] count;
  logic          overflow;
  logic          room;
  logic [7:0]    pkt_buf [KEEP];

  assign room = (count < CW'(MAX_PACKET_BYTES));

  // Store the leading bytes; later ones are never decoded
  for (genvar j = 0; j < KEEP; j++) begin : g_buf
    always_ff @(posedge clk) begin
      if (accept && (count == CW'(j))) begin
        pkt_buf[j] <= byte_item.packet_byte;
      end
    end
  end

  // Build the record: received bytes, the byte now arriving, zero beyond
  for (genvar j = 0; j < dmpd_pkg::REC_BYTES; j++) begin : g_rec
    if (j < KEEP) begin : g_kept
      always_comb begin
        if (count > CW'(j)) begin
          rec.bytes[j] = pkt_buf[j];
        end else if (count == CW'(j)) begin
          rec.bytes[j] = byte_item.packet_byte;
        end else begin
          rec.bytes[j] = 8'h00;
        end
      end
    end else begin : g_absent
      assign rec.bytes[j] = 8'h00;
    end
  end

  assign rec.size       = dmpd_pkg::SIZE_W'(count) + dmpd_pkg::SIZE_W'(1);
  assign rec.final_byte = byte_item.packet_byte;
  assign rec_push       = accept && byte_item.last_byte_flag && room && !overflow;

  // Count bytes, flag over-long packets, restart on the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (accept) begin
      if (byte_item.last_byte_flag) begin
        count    <= '0;
        overflow <= 1'b0;
      end else if (room) begin
        count <= count + CW'(1);
      end else begin
        overflow <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/dmpd_back.sv =====
// Back of the decoder: decodes one packet a cycle while out_room is high,
// updates held speed, direction, functions, confirms CV writes. Uses dmpd_pkg.
`timescale 1ns / 1ps

module dmpd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pkt_valid,
  input  dmpd_pkg::pkt_rec_t  rec,
  output logic                pkt_pop,
  input  logic                out_room,
  output logic                res_push,
  output dmpd_pkg::result_t   res,
  input  dmpd_pkg::cfg_regs_t regs,
  output dmpd_pkg::mode_wr_t  mode_wr
);

  logic [6:0]  speed;
  logic        dir;
  logic [28:0] funcs;
  logic [7:0]  prev_final;

  logic [6:0]  speed_next;
  logic        dir_next;
  logic [28:0] funcs_next;

  logic        s;
  logic [13:0] dcc_addr;
  logic [13:0] active_addr;
  logic [7:0]  hi_off;
  logic        addr_valid;
  logic        primary;
  logic        matched;
  logic [7:0]  instr;
  logic [7:0]  d;
  logic [7:0]  val;
  logic [dmpd_pkg::SIZE_W-1:0] size_basic;
  logic [dmpd_pkg::SIZE_W-1:0] size_data;
  logic        is_cv_write;
  logic        confirm;
  logic        reset_req;
  logic        cv_valid;
  logic [8:0]  cv_num;

  // Derive the primary address from the registers
  assign hi_off = regs.long_high - dmpd_pkg::LONG_HIGH_MIN;
  always_comb begin
    if (regs.mode[dmpd_pkg::MODE_LONG_BIT]) begin
      addr_valid  = (regs.long_high >= dmpd_pkg::LONG_HIGH_MIN) &&
                    (regs.long_high <= dmpd_pkg::LONG_HIGH_MAX);
      active_addr = {hi_off[5:0], regs.long_low};
    end else begin
      addr_valid  = (regs.short_addr >= dmpd_pkg::SHORT_ADDR_MIN) &&
                    (regs.short_addr <= dmpd_pkg::SHORT_ADDR_MAX);
      active_addr = {6'd0, regs.short_addr};
    end
  end

  // Pick the address and the fields that follow it
  assign s          = rec.bytes[0][7];
  assign dcc_addr   = s ? {rec.bytes[0][5:0], rec.bytes[1]} : {7'd0, rec.bytes[0][6:0]};
  assign instr      = s ? rec.bytes[2] : rec.bytes[1];
  assign d          = s ? rec.bytes[3] : rec.bytes[2];
  assign val        = s ? rec.bytes[4] : rec.bytes[3];
  assign size_basic = s ? dmpd_pkg::SIZE_W'(3) : dmpd_pkg::SIZE_W'(2);
  assign size_data  = size_basic + dmpd_pkg::SIZE_W'(1);

  assign primary = addr_valid && (dcc_addr == active_addr);
  assign matched = primary || (dcc_addr == {7'd0, regs.consist[6:0]});

  // Confirm a CV write when the final byte repeats
  assign is_cv_write = primary &&
      ((instr & dmpd_pkg::INSTR_CV_WRITE_MASK) == dmpd_pkg::INSTR_CV_WRITE);
  assign confirm   = is_cv_write && (rec.final_byte == prev_final);
  assign reset_req = confirm && (d == dmpd_pkg::CV_RESET_INDEX) &&
                     (val == dmpd_pkg::CV_RESET_VALUE);
  assign cv_valid  = confirm && !reset_req;
  assign cv_num    = {1'b0, d} + 9'd1;

  // Work out the new speed, direction and functions
  always_comb begin
    speed_next = speed;
    dir_next   = dir;
    funcs_next = funcs;
    if (matched && !is_cv_write) begin
      if (!instr[7]) begin
        if ((instr == dmpd_pkg::INSTR_SPEED_128) && (rec.size == size_data)) begin
          dir_next   = d[7];
          speed_next = (d[6:0] == 7'd0) ? 7'd0 : d[6:0] - 7'd1;
        end else if (rec.size == size_basic) begin
          dir_next   = instr[5];
          speed_next = {2'd0, instr[4:0]};
        end else begin
          dir_next   = 1'b1;
          speed_next = 7'd0;
        end
      end else if ((instr & dmpd_pkg::INSTR_FG1_MASK) == dmpd_pkg::INSTR_FG1) begin
        funcs_next[0]   = instr[4];
        funcs_next[4:1] = instr[3:0];
      end else if ((instr & dmpd_pkg::INSTR_FG2_MASK) == dmpd_pkg::INSTR_FG2_LOW) begin
        funcs_next[8:5] = instr[3:0];
      end else if ((instr & dmpd_pkg::INSTR_FG2_MASK) == dmpd_pkg::INSTR_FG2_HIGH) begin
        funcs_next[12:9] = instr[3:0];
      end else if (instr == dmpd_pkg::INSTR_F13_F20) begin
        if (rec.size >= size_data) begin
          funcs_next[20:13] = d;
        end
      end else if (instr == dmpd_pkg::INSTR_F21_F28) begin
        if (rec.size >= size_data) begin
          funcs_next[28:21] = d;
        end
      end
    end
  end

  // Form the result
  assign pkt_pop  = pkt_valid && out_room;
  assign res_push = pkt_pop;

  always_comb begin
    res.address_matched       = matched;
    res.speed_step            = speed_next;
    res.direction_out         = dir_next;
    res.function_outputs      = funcs_next;
    res.state_changed         = (speed_next != speed) || (dir_next != dir) ||
                                (funcs_next != funcs);
    res.cv_write_valid        = cv_valid;
    res.cv_number             = confirm ? cv_num : 9'd0;
    res.cv_value              = confirm ? val : 8'd0;
    res.decoder_reset_request = reset_req;
  end

  // Request a mode register update on a confirmed CV29 write
  assign mode_wr.en    = pkt_pop && cv_valid && (cv_num == dmpd_pkg::CV_MODE_NUMBER);
  assign mode_wr.value = val;

  // Hold decoder state; advance it per consumed packet
  always_ff @(posedge clk) begin
    if (rst) begin
      speed      <= 7'd0;
      dir        <= 1'b1;
      funcs      <= 29'd0;
      prev_final <= 8'd0;
    end else if (pkt_pop) begin
      speed      <= speed_next;
      dir        <= dir_next;
      funcs      <= funcs_next;
      prev_final <= rec.final_byte;
    end
  end

  a_cv_write_shape: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.cv_write_valid) |-> (res.address_matched && !res.state_changed))
    else $error("confirmed CV write with unmatched address or state change");

  a_reset_req_shape: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.decoder_reset_request) |->
    (!res.cv_write_valid && (res.cv_number == 9'd8) && (res.cv_value == 8'd8)))
    else $error("decoder reset request with wrong CV fields");

  a_mode_wr_source: assert property (@(posedge clk) disable iff (rst)
    mode_wr.en |-> (res_push && res.cv_write_valid && res.address_matched))
    else $error("mode update without a confirmed CV write");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(pkt_pop)) |-> ($stable(speed) && $stable(dir) && $stable(funcs)))
    else $error("decoder state changed without a packet");

endmodule

// ===== hdl/dcc_mobile_packet_decoder.sv =====
// DCC mobile packet decoder. Packet bytes are pushed one per clock while
// full is low; the front collects them and, on the byte marked last, queues
// the whole packet in a two-entry queue. The back decodes one queued packet
// per clock while the two-entry result queue has room, so each side can stall
// on its own. Sustained rate is one byte per cycle when nothing stalls. A
// final byte's packet is registered in the packet queue, decoded from its
// head and its result registered in the result queue. Non-final bytes and
// dropped over-long packets give no result. full follows the packet queue,
// and the registers are read and written over APB at byte addresses 0, 4,
// 8, 12 and 16. Depends on dmpd_pkg, dmpd_fifo, dmpd_front and dmpd_back.
`timescale 1ns / 1ps

module dcc_mobile_packet_decoder #(
  parameter int MAX_PACKET_BYTES = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dmpd_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           push,
  output logic                           full,
  input  dmpd_pkg::in_item_t             byte_item,
  output logic                           empty,
  input  logic                           pop,
  output dmpd_pkg::result_t              result
);

  localparam int REC_W = $bits(dmpd_pkg::pkt_rec_t);
  localparam int RES_W = $bits(dmpd_pkg::result_t);

  dmpd_pkg::cfg_regs_t regs;
  dmpd_pkg::mode_wr_t  mode_wr;
  dmpd_pkg::pkt_rec_t  rec_in;
  dmpd_pkg::result_t   res;

  logic [dmpd_pkg::REG_IDX_W-1:0] reg_idx;
  logic             cfg_wr;
  logic             accept;
  logic             rec_push;
  logic             pkt_full;
  logic             pkt_empty;
  logic             pkt_pop;
  logic [REC_W-1:0] pkt_rdata;
  logic             res_push;
  logic             res_full;
  logic [RES_W-1:0] res_rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[dmpd_pkg::PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration registers; a confirmed CV29 write sets mode if no APB write
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.short_addr <= dmpd_pkg::RST_SHORT_ADDR;
      regs.long_high  <= dmpd_pkg::RST_LONG_HIGH;
      regs.long_low   <= dmpd_pkg::RST_LONG_LOW;
      regs.consist    <= dmpd_pkg::RST_CONSIST;
      regs.mode       <= dmpd_pkg::RST_MODE;
    end else if (cfg_wr) begin
      case (reg_idx)
        dmpd_pkg::REG_SHORT_ADDR: regs.short_addr <= pwdata[7:0];
        dmpd_pkg::REG_LONG_HIGH:  regs.long_high  <= pwdata[7:0];
        dmpd_pkg::REG_LONG_LOW:   regs.long_low   <= pwdata[7:0];
        dmpd_pkg::REG_CONSIST:    regs.consist    <= pwdata[7:0];
        dmpd_pkg::REG_MODE:       regs.mode       <= pwdata[7:0];
        default: begin
        end
      endcase
    end else if (mode_wr.en) begin
      regs.mode <= mode_wr.value;
    end
  end

  // Register read-back
  always_comb begin
    case (reg_idx)
      dmpd_pkg::REG_SHORT_ADDR: prdata = {24'd0, regs.short_addr};
      dmpd_pkg::REG_LONG_HIGH:  prdata = {24'd0, regs.long_high};
      dmpd_pkg::REG_LONG_LOW:   prdata = {24'd0, regs.long_low};
      dmpd_pkg::REG_CONSIST:    prdata = {24'd0, regs.consist};
      dmpd_pkg::REG_MODE:       prdata = {24'd0, regs.mode};
      default:                  prdata = 32'd0;
    endcase
  end

  // Byte collection
  assign full   = pkt_full;
  assign accept = push && !pkt_full;

  dmpd_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .byte_item(byte_item),
    .rec_push (rec_push),
    .rec      (rec_in)
  );

  // Packet queue between front and back
  dmpd_fifo #(
    .WIDTH(REC_W)
  ) u_pkt_q (
    .clk  (clk),
    .rst  (rst),
    .push (rec_push),
    .wdata(rec_in),
    .full (pkt_full),
    .pop  (pkt_pop),
    .rdata(pkt_rdata),
    .empty(pkt_empty)
  );

  // Packet decode
  dmpd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pkt_valid(!pkt_empty),
    .rec      (dmpd_pkg::pkt_rec_t'(pkt_rdata)),
    .pkt_pop  (pkt_pop),
    .out_room (!res_full),
    .res_push (res_push),
    .res      (res),
    .regs     (regs),
    .mode_wr  (mode_wr)
  );

  // Result queue
  dmpd_fifo #(
    .WIDTH(RES_W)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res),
    .full (res_full),
    .pop  (pop),
    .rdata(res_rdata),
    .empty(empty)
  );

  assign result = dmpd_pkg::result_t'(res_rdata);

endmodule

// ===== tb/sv/dmpd_checker.sv =====
// Checker for the DCC mobile packet decoder: follows register writes, byte
// requests and status pops, predicts each status report and compares it.
// Depends on dmpd_pkg for the channel types, register indexes and codes.
`timescale 1ns / 1ps

module dmpd_status_checker #(
  parameter int MAX_PACKET_BYTES = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [dmpd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  input  logic                         push,
  input  logic                         full,
  input  dmpd_pkg::in_item_t           byte_item,
  input  logic                         pop,
  input  logic                         empty,
  input  dmpd_pkg::result_t            result,
  output int                           mismatch_count,
  output int                           reports_owed
);
  import dmpd_pkg::*;

  // Decoder state as seen from outside
  logic [7:0]  pkt_buf [MAX_PACKET_BYTES];
  int          pkt_len;
  bit          pkt_overflow;
  cfg_regs_t   regs;
  logic [15:0] primary_addr;
  bit          primary_ok;
  logic [7:0]  last_final;
  logic [6:0]  speed_now;
  logic        dir_now;
  logic [28:0] funcs_now;

  result_t status_queue[$];

  // Recompute the primary address from the stored CVs
  function automatic void refresh_primary();
    if (regs.mode[MODE_LONG_BIT]) begin
      primary_ok = regs.long_high >= LONG_HIGH_MIN && regs.long_high <= LONG_HIGH_MAX;
      primary_addr = primary_ok ? {regs.long_high - LONG_HIGH_MIN, regs.long_low} : 16'h0000;
    end else begin
      primary_ok = regs.short_addr >= SHORT_ADDR_MIN && regs.short_addr <= SHORT_ADDR_MAX;
      primary_addr = primary_ok ? {8'h00, regs.short_addr} : 16'h0000;
    end
  endfunction

  function automatic void reset_state();
    pkt_len = 0;
    pkt_overflow = 0;
    regs.short_addr = RST_SHORT_ADDR;
    regs.long_high = RST_LONG_HIGH;
    regs.long_low = RST_LONG_LOW;
    regs.consist = RST_CONSIST;
    regs.mode = RST_MODE;
    last_final = 8'h00;
    speed_now = 7'd0;
    dir_now = 1'b1;
    funcs_now = '0;
    refresh_primary();
  endfunction

  // Bytes not received in this packet read as zero
  function automatic logic [7:0] byte_of(int i, int size);
    return (i < size) ? pkt_buf[i] : 8'h00;
  endfunction

  // Take one byte request; on the final byte decode the packet and build the report
  function automatic bit decode_byte(input in_item_t item, output result_t rep);
    logic [7:0]  instr, data, cv_idx, cv_val, last_b;
    logic [15:0] addr;
    logic [6:0]  nspeed;
    logic        ndir;
    logic [28:0] nfuncs;
    int          size, s;
    bit          primary, matched;
    rep = '0;
    if (pkt_len < MAX_PACKET_BYTES) begin
      pkt_buf[pkt_len] = item.packet_byte;
      pkt_len++;
    end else begin
      pkt_overflow = 1;
    end
    if (!item.last_byte_flag) return 0;
    size = pkt_len;
    pkt_len = 0;
    // drop over-long packets without a trace
    if (pkt_overflow) begin
      pkt_overflow = 0;
      return 0;
    end
    s = pkt_buf[0][7] ? 1 : 0;
    addr = s ? {2'b00, pkt_buf[0][5:0], byte_of(1, size)} : {9'd0, pkt_buf[0][6:0]};
    primary = primary_ok && addr == primary_addr;
    matched = primary || addr == {9'd0, regs.consist[6:0]};
    instr = byte_of(1 + s, size);
    data = byte_of(2 + s, size);
    last_b = pkt_buf[size - 1];
    nspeed = speed_now;
    ndir = dir_now;
    nfuncs = funcs_now;
    if (primary && (instr & INSTR_CV_WRITE_MASK) == INSTR_CV_WRITE) begin
      // act only on the repeat of the same write
      if (last_b == last_final) begin
        cv_idx = data;
        cv_val = byte_of(3 + s, size);
        rep.cv_number = {1'b0, cv_idx} + 9'd1;
        rep.cv_value = cv_val;
        if (cv_idx == CV_RESET_INDEX && cv_val == CV_RESET_VALUE) begin
          rep.decoder_reset_request = 1'b1;
        end else begin
          rep.cv_write_valid = 1'b1;
          if (rep.cv_number == CV_MODE_NUMBER) begin
            regs.mode = cv_val;
            refresh_primary();
          end
        end
      end
    end else if (matched) begin
      if (!instr[7]) begin
        if (instr == INSTR_SPEED_128 && size == 3 + s) begin
          ndir = data[7];
          nspeed = (data[6:0] != 7'd0) ? data[6:0] - 7'd1 : 7'd0;
        end else if (size == 2 + s) begin
          ndir = instr[5];
          nspeed = {2'b00, instr[4:0]};
        end else begin
          ndir = 1'b1;
          nspeed = 7'd0;
        end
      end else if ((instr & INSTR_FG1_MASK) == INSTR_FG1) begin
        nfuncs[4:0] = {instr[3:0], instr[4]};
      end else if ((instr & INSTR_FG2_MASK) == INSTR_FG2_LOW) begin
        nfuncs[8:5] = instr[3:0];
      end else if ((instr & INSTR_FG2_MASK) == INSTR_FG2_HIGH) begin
        nfuncs[12:9] = instr[3:0];
      end else if (instr == INSTR_F13_F20) begin
        if (size >= 3 + s) nfuncs[20:13] = data;
      end else if (instr == INSTR_F21_F28) begin
        if (size >= 3 + s) nfuncs[28:21] = data;
      end
      rep.state_changed = nspeed != speed_now || ndir != dir_now || nfuncs != funcs_now;
      speed_now = nspeed;
      dir_now = ndir;
      funcs_now = nfuncs;
    end
    last_final = last_b;
    rep.address_matched = matched;
    rep.speed_step = speed_now;
    rep.direction_out = dir_now;
    rep.function_outputs = funcs_now;
    return 1;
  endfunction

  function automatic void compare_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0h got %0h", $time, fname, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t rep, want;
    if (rst) begin
      reset_state();
      status_queue.delete();
      mismatch_count = 0;
    end else begin
      // follow register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[dmpd_pkg::PADDR_W-1:2])
          REG_SHORT_ADDR: regs.short_addr = pwdata[7:0];
          REG_LONG_HIGH:  regs.long_high = pwdata[7:0];
          REG_LONG_LOW:   regs.long_low = pwdata[7:0];
          REG_CONSIST:    regs.consist = pwdata[7:0];
          REG_MODE:       regs.mode = pwdata[7:0];
          default: ;
        endcase
        refresh_primary();
      end
      // predict on each accepted byte request
      if (push && !full) begin
        if (decode_byte(byte_item, rep)) status_queue.push_back(rep);
      end
      // compare each popped report with the oldest prediction
      if (pop && !empty) begin
        if (status_queue.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected report, expected none got %0h", $time, result);
        end else begin
          want = status_queue.pop_front();
          compare_field("address_matched", want.address_matched, result.address_matched);
          compare_field("speed_step", want.speed_step, result.speed_step);
          compare_field("direction_out", want.direction_out, result.direction_out);
          compare_field("function_outputs", want.function_outputs, result.function_outputs);
          compare_field("state_changed", want.state_changed, result.state_changed);
          compare_field("cv_write_valid", want.cv_write_valid, result.cv_write_valid);
          compare_field("cv_number", want.cv_number, result.cv_number);
          compare_field("cv_value", want.cv_value, result.cv_value);
          compare_field("decoder_reset_request", want.decoder_reset_request,
                        result.decoder_reset_request);
        end
      end
    end
    reports_owed <= status_queue.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the DCC mobile packet decoder bench: clock, reset, register setup,
// packet byte requests and status pops, and the verdict.
// Depends on dmpd_pkg, the decoder RTL and dmpd_status_checker.
`timescale 1ns / 1ps

module testbench;
  import dmpd_pkg::*;

  localparam int MAX_BYTES    = 6;
  localparam int PHASE_BYTES  = 180;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 push = 1'b0;
  logic                 full;
  in_item_t             byte_item = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  result_t              result;

  int mismatch_count;
  int reports_owed;

  // Stimulus control shared by the sender and the receiver
  logic calm = 1'b0;
  logic hold_results = 1'b0;
  int   sent_bytes = 0;
  bit   send_twice;
  logic [7:0] pkt_q[$];
  logic [7:0] cfg_short, cfg_high, cfg_low, cfg_consist;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  dcc_mobile_packet_decoder #(
    .MAX_PACKET_BYTES(MAX_BYTES)
  ) u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full), .byte_item(byte_item),
    .empty(empty), .pop(pop), .result(result)
  );

  dmpd_status_checker #(
    .MAX_PACKET_BYTES(MAX_BYTES)
  ) u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .push(push), .full(full), .byte_item(byte_item),
    .pop(pop), .empty(empty), .result(result),
    .mismatch_count(mismatch_count), .reports_owed(reports_owed)
  );

  function automatic logic [7:0] rand_byte();
    logic [31:0] bits;
    bits = $urandom;
    return bits[7:0];
  endfunction

  // Write one register: setup phase, access phase until pready, then an idle phase
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, val[7:0]};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SHORT_ADDR: cfg_short = val[7:0];
      REG_LONG_HIGH:  cfg_high = val[7:0];
      REG_LONG_LOW:   cfg_low = val[7:0];
      REG_CONSIST:    cfg_consist = val[7:0];
      default: ;
    endcase
  endtask

  // Offer one byte request, with random gaps unless calm, and hold until taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!calm) begin
      while ($urandom_range(99) < 17) begin
        push <= 1'b0;
        @(posedge clk);
      end
    end
    push <= 1'b1;
    byte_item <= {b, last};
    @(posedge clk);
    while (full) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_pkt();
    for (int i = 0; i < pkt_q.size(); i++) send_byte(pkt_q[i], i == pkt_q.size() - 1);
  endtask

  task automatic send_fixed(input int n, input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input logic [7:0] b3);
    pkt_q.delete();
    pkt_q.push_back(b0);
    if (n > 1) pkt_q.push_back(b1);
    if (n > 2) pkt_q.push_back(b2);
    if (n > 3) pkt_q.push_back(b3);
    send_pkt();
  endtask

  // Address bytes: 0 primary short, 1 primary long, 2/3 consist short/long, else random
  task automatic put_header(input int pick);
    logic [7:0] b0;
    logic       r1;
    r1 = $urandom_range(1);
    case (pick)
      0: pkt_q.push_back({1'b0, cfg_short[6:0]});
      1: begin
        b0 = cfg_high - LONG_HIGH_MIN;
        pkt_q.push_back({1'b1, r1, b0[5:0]});
        pkt_q.push_back(cfg_low);
      end
      2: pkt_q.push_back({1'b0, cfg_consist[6:0]});
      3: begin
        pkt_q.push_back({1'b1, r1, 6'd0});
        pkt_q.push_back({1'b0, cfg_consist[6:0]});
      end
      default: begin
        b0 = rand_byte();
        pkt_q.push_back(b0);
        if (b0[7]) pkt_q.push_back(rand_byte());
      end
    endcase
  endtask

  function automatic int pick_target();
    int r;
    r = $urandom_range(9);
    if (r < 4) return 0;
    if (r < 6) return 1;
    if (r < 7) return 2;
    if (r < 8) return 3;
    return 4;
  endfunction

  // Build one random packet: mostly well-formed commands, some noise
  task automatic build_packet();
    int         kind, n, r;
    logic [7:0] b;
    pkt_q.delete();
    send_twice = 0;
    kind = $urandom_range(99);
    if (kind >= 85) begin
      // over-long or fully random packets
      n = (kind >= 93) ? $urandom_range(1, MAX_BYTES) :
                         $urandom_range(MAX_BYTES + 1, MAX_BYTES + 3);
      repeat (n) pkt_q.push_back(rand_byte());
    end else if (kind >= 60 && kind < 75) begin
      // CV write, usually repeated to confirm it
      put_header($urandom_range(1));
      b = rand_byte();
      pkt_q.push_back({INSTR_CV_WRITE[7:2], b[1:0]});
      r = $urandom_range(9);
      if (r == 0) begin
        pkt_q.push_back(CV_RESET_INDEX);
        pkt_q.push_back(CV_RESET_VALUE);
      end else if (r == 1) begin
        pkt_q.push_back(CV_MODE_NUMBER[7:0] - 8'd1);
        pkt_q.push_back(rand_byte());
      end else begin
        pkt_q.push_back(rand_byte());
        pkt_q.push_back(rand_byte());
      end
      send_twice = $urandom_range(3) != 0;
    end else begin
      put_header(pick_target());
      b = rand_byte();
      if (kind < 15) begin
        pkt_q.push_back(INSTR_SPEED_128);
        pkt_q.push_back(b);
      end else if (kind < 25) begin
        pkt_q.push_back({1'b0, b[6:0]});
      end else if (kind < 30) begin
        pkt_q.push_back({1'b0, b[6:0]});
        repeat ($urandom_range(0, 2)) pkt_q.push_back(rand_byte());
      end else if (kind < 40) begin
        pkt_q.push_back({3'b100, b[4:0]});
      end else if (kind < 50) begin
        pkt_q.push_back({3'b101, b[4:0]});
      end else if (kind < 55) begin
        pkt_q.push_back(INSTR_F13_F20);
        if ($urandom_range(4) != 0) pkt_q.push_back(rand_byte());
      end else if (kind < 60) begin
        pkt_q.push_back(INSTR_F21_F28);
        if ($urandom_range(4) != 0) pkt_q.push_back(rand_byte());
      end else begin
        pkt_q.push_back(b);
        repeat ($urandom_range(0, 3)) pkt_q.push_back(rand_byte());
      end
    end
  endtask

  // Stop offering and wait until every report has been popped
  task automatic drain_and_wait();
    push <= 1'b0;
    @(posedge clk);
    while (reports_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register setting for each random phase, extremes first
  task automatic apply_setting(input int phase);
    case (phase)
      1: begin
        reg_write(REG_SHORT_ADDR, 127);
        reg_write(REG_LONG_HIGH, 231);
        reg_write(REG_LONG_LOW, 255);
        reg_write(REG_CONSIST, 127);
        reg_write(REG_MODE, 8'h10);
      end
      2: begin
        reg_write(REG_SHORT_ADDR, 0);
        reg_write(REG_CONSIST, 255);
        reg_write(REG_MODE, 8'h00);
      end
      3: begin
        reg_write(REG_LONG_HIGH, 191);
        reg_write(REG_MODE, 8'hFF);
      end
      4: begin
        reg_write(REG_SHORT_ADDR, 128);
        reg_write(REG_LONG_HIGH, 232);
        reg_write(REG_MODE, 8'h10);
      end
      5: begin
        reg_write(REG_SHORT_ADDR, 255);
        reg_write(REG_LONG_HIGH, 192);
        reg_write(REG_LONG_LOW, 0);
        reg_write(REG_MODE, 8'hEF);
      end
      6: begin
        reg_write(REG_SHORT_ADDR, $urandom_range(3, 127));
        reg_write(REG_LONG_HIGH, $urandom_range(192, 231));
        reg_write(REG_LONG_LOW, $urandom_range(255));
        reg_write(REG_CONSIST, $urandom_range(255));
        reg_write(REG_MODE, $urandom_range(255));
      end
      default: begin
        reg_write(REG_SHORT_ADDR, $urandom_range(255));
        reg_write(REG_LONG_HIGH, $urandom_range(255));
        reg_write(REG_LONG_LOW, $urandom_range(255));
        reg_write(REG_CONSIST, $urandom_range(255));
        reg_write(REG_MODE, $urandom_range(255));
      end
    endcase
  endtask

  // Pop side: random stalls, plus one long hold-off on request
  initial begin : drain
    forever begin
      @(posedge clk);
      if (hold_results) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results <= 1'b0;
      end else if (rst) begin
        pop <= 1'b0;
      end else begin
        pop <= calm || ($urandom_range(99) >= 17);
      end
    end
  end

  initial begin : stimulus
    int target;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    reg_write(REG_SHORT_ADDR, RST_SHORT_ADDR);
    reg_write(REG_LONG_HIGH, RST_LONG_HIGH);
    reg_write(REG_LONG_LOW, RST_LONG_LOW);
    reg_write(REG_CONSIST, RST_CONSIST);
    reg_write(REG_MODE, RST_MODE);

    // directed packets at the default short address
    send_fixed(2, 8'h03, 8'h75, 8'h00, 8'h00);
    send_fixed(3, 8'h03, INSTR_SPEED_128, 8'h80, 8'h00);
    send_fixed(2, 8'h03, 8'h9F, 8'h00, 8'h00);
    send_fixed(2, 8'h03, 8'hBF, 8'h00, 8'h00);
    send_fixed(3, 8'h03, INSTR_F13_F20, 8'hFF, 8'h00);
    send_fixed(2, 8'h03, INSTR_F21_F28, 8'h00, 8'h00);
    send_fixed(4, 8'h03, 8'h40, 8'h11, 8'h22);
    // reset request: first copy arms it, second confirms
    repeat (2) send_fixed(4, 8'h03, INSTR_CV_WRITE, CV_RESET_INDEX, CV_RESET_VALUE);
    // over-long packet is dropped
    pkt_q.delete();
    repeat (MAX_BYTES + 1) pkt_q.push_back(rand_byte());
    send_pkt();

    // random phases, one register setting each
    for (int phase = 1; phase <= 7; phase++) begin
      drain_and_wait();
      apply_setting(phase);
      if (phase == 3) hold_results <= 1'b1;
      calm <= (phase == 5);
      target = sent_bytes + PHASE_BYTES;
      while (sent_bytes < target) begin
        build_packet();
        send_pkt();
        if (send_twice) send_pkt();
      end
    end

    drain_and_wait();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Guard against a hang
  initial begin : watchdog
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
